>>> hdl/pli_pkg.sv
// Shared types and codes for the positional list block.
`default_nettype none
package pli_pkg;

	localparam int HandleW = 12;
	localparam int PosW    = 7;
	localparam int OpW     = 3;
	localparam int StatW   = 2;
	localparam int ReportW = 7;

	typedef enum logic [OpW-1:0] {
		OP_INS_POS  = 3'd0,
		OP_INS_HEAD = 3'd1,
		OP_INS_TAIL = 3'd2,
		OP_REM_POS  = 3'd3,
		OP_REM_HEAD = 3'd4,
		OP_REM_TAIL = 3'd5
	} op_t;

	typedef enum logic [StatW-1:0] {
		ST_OK     = 2'd0,
		ST_BADPOS = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_TAKE,
		S_GRAB,
		S_READ,
		S_WRITE,
		S_DONE
	} state_t;

endpackage
`default_nettype wire

>>> hdl/positional_list_insert_remove.sv
// Bounded positional list: insert/remove by position, head or tail, with entry shifting.
//
//  channel | dir | beat payload
//  --------+-----+---------------------------------------------------------
//  s_*     | in  | tdata: opcode[2:0], position[9:3], item_handle[21:10]
//  m_*     | out | tdata: status[1:0], removed_item[13:2], entry_count[20:14]
//
// Rejected beats and unknown opcodes finish in the accept cycle.
// Position ops shift entries in a loop: each entry moves by a registered read, then a write.
// arst_n clears the count and control; entry memory holds no reset.
// s_tready is low while an operation runs or while a result waits on m_tready.
`default_nettype none
module positional_list_insert_remove
	import pli_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // opcode, position, item_handle (low bit up)
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata    // status, removed_item, entry_count (low bit up)
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int EW = (CW > PosW) ? CW : PosW;

	// input unpack
	op_t                op;
	logic [PosW-1:0]    position;
	logic [HandleW-1:0] item_handle;
	logic               accept;

	assign op          = op_t'(s_tdata[2:0]);
	assign position    = s_tdata[9:3];
	assign item_handle = s_tdata[21:10];
	assign accept      = s_tvalid && s_tready;

	// state
	state_t             state_q, state_d;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      dst_q;
	logic [CW-1:0]      end_q;
	logic [CW-1:0]      tpos_q;
	logic               ins_q;
	logic [HandleW-1:0] handle_q;
	logic [HandleW-1:0] taken_q;
	logic [HandleW-1:0] rdata_q;
	logic [HandleW-1:0] mem [CAPACITY];

	logic               out_valid_q;
	status_t            res_status_q;
	logic [HandleW-1:0] res_item_q;
	logic [ReportW-1:0] res_count_q;

	// accept-time check
	logic [EW-1:0] cnt_ext, pos_ext, acc_tpos_e;
	logic [CW-1:0] acc_tpos;
	logic          acc_err, acc_ins, full, empty;
	status_t       acc_status;

	assign cnt_ext = EW'(cnt_q);
	assign pos_ext = EW'(position);
	assign full    = (cnt_q == CW'(CAPACITY));
	assign empty   = (cnt_q == '0);

	always_comb begin
		acc_err    = 1'b1;
		acc_status = ST_BADPOS;
		acc_ins    = 1'b0;
		acc_tpos_e = '0;
		unique case (op)
			OP_INS_POS: begin
				acc_ins = 1'b1;
				if (pos_ext > cnt_ext) begin
					acc_status = ST_BADPOS;
				end else if (full) begin
					acc_status = ST_FULL;
				end else begin
					acc_err    = 1'b0;
					acc_status = ST_OK;
					acc_tpos_e = pos_ext;
				end
			end
			OP_INS_HEAD, OP_INS_TAIL: begin
				acc_ins = 1'b1;
				if (full) begin
					acc_status = ST_FULL;
				end else begin
					acc_err    = 1'b0;
					acc_status = ST_OK;
					acc_tpos_e = (op == OP_INS_TAIL) ? cnt_ext : '0;
				end
			end
			OP_REM_POS: begin
				if (empty) begin
					acc_status = ST_EMPTY;
				end else if (pos_ext >= cnt_ext) begin
					acc_status = ST_BADPOS;
				end else begin
					acc_err    = 1'b0;
					acc_status = ST_OK;
					acc_tpos_e = pos_ext;
				end
			end
			OP_REM_HEAD, OP_REM_TAIL: begin
				if (empty) begin
					acc_status = ST_EMPTY;
				end else begin
					acc_err    = 1'b0;
					acc_status = ST_OK;
					acc_tpos_e = (op == OP_REM_TAIL) ? cnt_ext - EW'(1) : '0;
				end
			end
			default: begin
				acc_err    = 1'b1;
				acc_status = ST_BADPOS;
			end
		endcase
	end

	assign acc_tpos = acc_tpos_e[CW-1:0];

	// shared step unit: neighbor index and end compare
	logic [CW-1:0] nb;
	logic [CW-1:0] cmp_a;
	logic          at_end;

	assign nb     = ins_q ? dst_q - CW'(1) : dst_q + CW'(1);
	assign cmp_a  = (state_q == S_GRAB) ? dst_q : nb;
	assign at_end = (cmp_a == end_q);

	logic res_free;
	assign res_free = !out_valid_q || m_tready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && !acc_err) begin
					if (acc_ins) begin
						state_d = (acc_tpos == cnt_q) ? S_DONE : S_READ;
					end else begin
						state_d = S_TAKE;
					end
				end
			end
			S_TAKE:  state_d = S_GRAB;
			S_GRAB:  state_d = at_end ? S_DONE : S_READ;
			S_READ:  state_d = S_WRITE;
			S_WRITE: state_d = at_end ? S_DONE : S_READ;
			S_DONE:  state_d = res_free ? S_IDLE : S_DONE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs of the sequencer
	logic               mem_we;
	logic [AW-1:0]      mem_waddr, mem_raddr;
	logic [HandleW-1:0] mem_wdata;
	logic               load_res;
	status_t            res_status;
	logic [HandleW-1:0] res_item;
	logic [CW-1:0]      cnt_new;
	logic               cnt_we;

	always_comb begin
		s_tready   = 1'b0;
		mem_we     = 1'b0;
		mem_waddr  = dst_q[AW-1:0];
		mem_wdata  = rdata_q;
		mem_raddr  = nb[AW-1:0];
		load_res   = 1'b0;
		res_status = ST_OK;
		res_item   = '0;
		cnt_new    = cnt_q;
		cnt_we     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready   = res_free;
				load_res   = accept && acc_err;
				res_status = acc_status;
			end
			S_TAKE: begin
				mem_raddr = dst_q[AW-1:0];
			end
			S_GRAB: begin
			end
			S_READ: begin
			end
			S_WRITE: begin
				mem_we = 1'b1;
			end
			S_DONE: begin
				load_res   = res_free;
				cnt_we     = res_free;
				res_status = ST_OK;
				if (ins_q) begin
					mem_we    = res_free;
					mem_waddr = tpos_q[AW-1:0];
					mem_wdata = handle_q;
					cnt_new   = cnt_q + CW'(1);
				end else begin
					res_item = taken_q;
					cnt_new  = cnt_q - CW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// entry memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[mem_raddr];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cnt_we) begin
				cnt_q <= cnt_new;
			end
			if (load_res) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	logic [EW-1:0] cnt_new_ext;
	assign cnt_new_ext = EW'(cnt_new);

	always_ff @(posedge clk) begin
		if (accept) begin
			ins_q    <= acc_ins;
			tpos_q   <= acc_tpos;
			handle_q <= item_handle;
			dst_q    <= acc_ins ? cnt_q : acc_tpos;
			end_q    <= acc_ins ? acc_tpos : cnt_q - CW'(1);
		end else if (state_q == S_WRITE) begin
			dst_q <= nb;
		end
		if (state_q == S_GRAB) begin
			taken_q <= rdata_q;
		end
		if (load_res) begin
			res_status_q <= res_status;
			res_item_q   <= res_item;
			res_count_q  <= cnt_new_ext[ReportW-1:0];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, res_count_q, res_item_q, res_status_q};

`ifndef ASSERT_OFF
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_cnt_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(cnt_q) |-> $past(state_q) == S_DONE)
		else $error("entry count changed outside completion");

	a_write_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WRITE |-> $past(state_q) == S_READ)
		else $error("shift write without a read");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_status_q == ST_EMPTY |-> res_count_q == '0)
		else $error("empty status with nonzero count");
`endif

endmodule
`default_nettype wire

>>> tb/positional_list_insert_remove_test.sv
// Testbench for the positional list: random and directed list ops checked against a shadow list.
`timescale 1ns / 100ps
module positional_list_insert_remove_test;
	import pli_pkg::*;

	localparam int LIST_CAP    = 64;
	localparam int HOLD_CYCLES = 400;
	localparam int IDLE_LIMIT  = 3000;
	localparam int RAND_OPS    = 1150;

	// opcodes with no meaning, still legal on the bus
	localparam logic [OpW-1:0] OP_SPARE_6 = 3'd6;
	localparam logic [OpW-1:0] OP_SPARE_7 = 3'd7;

	typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIX} mode_t;

	typedef struct {
		status_t             status;
		logic [HandleW-1:0]  removed;
		logic [ReportW-1:0]  count;
	} reply_t;

	class list_tracker;
		logic [HandleW-1:0] shadow_list[$];
		reply_t             expected_replies[$];
		int                 mismatches = 0;

		task flag_mismatch(string msg);
			$display("MISMATCH @%0t: %s", $realtime, msg);
			mismatches++;
		endtask

		function int pending();
			return expected_replies.size();
		endfunction

		function int depth();
			return shadow_list.size();
		endfunction

		// apply one accepted op to the shadow list and queue its reply
		function void apply_op(logic [OpW-1:0] op, logic [PosW-1:0] pos,
				logic [HandleW-1:0] handle);
			reply_t r;
			int     n;
			int     at;
			n = shadow_list.size();
			r.removed = '0;
			case (op)
				OP_INS_POS, OP_INS_HEAD, OP_INS_TAIL: begin
					at = (op == OP_INS_POS) ? int'(pos) : (op == OP_INS_HEAD) ? 0 : n;
					if (at > n)
						r.status = ST_BADPOS;
					else if (n >= LIST_CAP)
						r.status = ST_FULL;
					else begin
						shadow_list.insert(at, handle);
						r.status = ST_OK;
					end
				end
				OP_REM_POS, OP_REM_HEAD, OP_REM_TAIL: begin
					at = (op == OP_REM_POS) ? int'(pos) : (op == OP_REM_HEAD) ? 0 : n - 1;
					// empty check wins over position check
					if (n == 0)
						r.status = ST_EMPTY;
					else if (at >= n)
						r.status = ST_BADPOS;
					else begin
						r.removed = shadow_list[at];
						shadow_list.delete(at);
						r.status = ST_OK;
					end
				end
				default: r.status = ST_BADPOS;
			endcase
			r.count = ReportW'(shadow_list.size());
			expected_replies.push_back(r);
		endfunction

		task check_reply(logic [StatW-1:0] status, logic [HandleW-1:0] removed,
				logic [ReportW-1:0] count);
			reply_t e;
			if (expected_replies.size() == 0) begin
				flag_mismatch($sformatf("reply with nothing expected: status %0d item %h count %0d",
					status, removed, count));
				return;
			end
			e = expected_replies.pop_front();
			if (status !== e.status)
				flag_mismatch($sformatf("status %0d, expected %s", status, e.status.name()));
			if (removed !== e.removed)
				flag_mismatch($sformatf("removed_item %h, expected %h", removed, e.removed));
			if (count !== e.count)
				flag_mismatch($sformatf("entry_count %0d, expected %0d", count, e.count));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // opcode, position, item_handle (low bit up)
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // status, removed_item, entry_count (low bit up)

	list_tracker tracker = new();
	bit          quiet = 1'b0;
	bit          hold_out = 1'b0;
	int          idle_cycles = 0;

	positional_list_insert_remove #(.CAPACITY(LIST_CAP)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// beat monitor: predict on input beats, check on output beats
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				tracker.apply_op(s_tdata[2:0], s_tdata[9:3], s_tdata[21:10]);
			if (m_tvalid && m_tready)
				tracker.check_reply(m_tdata[1:0], m_tdata[13:2], m_tdata[20:14]);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else if (idle_cycles + 1 >= IDLE_LIMIT) begin
				$display("positional_list_insert_remove verification failed");
				$finish;
			end else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// result side
	initial begin
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_out) begin
				m_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_out = 1'b0;
			end
			stall = quiet ? 0 : $urandom_range(0, 11);
			if (stall > 0) begin
				m_tready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready = 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	task automatic send_op(input logic [OpW-1:0] op, input logic [PosW-1:0] pos,
			input logic [HandleW-1:0] handle);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata = {2'b00, handle, pos, op};
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid = 1'b0;
		while (tracker.pending() != 0)
			@(negedge clk);
	endtask

	// random op shaped by the current mode; some noise and unknown opcodes
	task automatic send_random_op(input int ins_pct);
		logic [OpW-1:0] op;
		logic [PosW-1:0] pos;
		int n;
		int pick;
		n = tracker.depth();
		pos = PosW'($urandom_range(0, 127));
		if ($urandom_range(0, 99) < 3)
			op = ($urandom_range(0, 1) != 0) ? OP_SPARE_7 : OP_SPARE_6;
		else if ($urandom_range(0, 99) < ins_pct) begin
			pick = $urandom_range(0, 2);
			op = (pick == 0) ? OP_INS_POS : (pick == 1) ? OP_INS_HEAD : OP_INS_TAIL;
			if ($urandom_range(0, 9) != 0)
				pos = PosW'($urandom_range(0, n));
		end else begin
			pick = $urandom_range(0, 2);
			op = (pick == 0) ? OP_REM_POS : (pick == 1) ? OP_REM_HEAD : OP_REM_TAIL;
			if (n > 0 && $urandom_range(0, 9) != 0)
				pos = PosW'($urandom_range(0, n - 1));
		end
		send_op(op, pos, HandleW'($urandom_range(0, 4095)));
	endtask

	initial begin
		mode_t mode;
		int    overshoot;
		int    mix_left;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty list, unknown ops, bad positions, head/tail/middle
		send_op(OP_REM_HEAD, 7'd0, 12'h000);
		send_op(OP_REM_TAIL, 7'd127, 12'hfff);
		send_op(OP_REM_POS, 7'd127, 12'h000);
		send_op(OP_SPARE_6, 7'd0, 12'hfff);
		send_op(OP_SPARE_7, 7'd127, 12'hfff);
		send_op(OP_INS_POS, 7'd1, 12'h111);
		send_op(OP_INS_POS, 7'd0, 12'h000);
		send_op(OP_INS_HEAD, 7'd127, 12'hfff);
		send_op(OP_INS_TAIL, 7'd64, 12'h5a5);
		send_op(OP_INS_POS, 7'd3, 12'ha5a);
		send_op(OP_INS_POS, 7'd1, 12'h123);
		send_op(OP_INS_POS, 7'd64, 12'h456);
		send_op(OP_INS_POS, 7'd127, 12'h789);
		send_op(OP_REM_POS, 7'd5, 12'h000);
		send_op(OP_REM_POS, 7'd127, 12'h000);
		send_op(OP_REM_POS, 7'd2, 12'hfff);
		send_op(OP_REM_HEAD, 7'd64, 12'h000);
		send_op(OP_REM_TAIL, 7'd0, 12'h000);
		send_op(OP_SPARE_7, 7'd0, 12'h000);
		send_op(OP_REM_POS, 7'd0, 12'h000);
		send_op(OP_REM_HEAD, 7'd0, 12'h000);
		send_op(OP_REM_TAIL, 7'd0, 12'h000);
		wait_drained();

		mode = MODE_FILL;
		overshoot = 0;
		mix_left = 0;
		for (int i = 0; i < RAND_OPS; i++) begin
			quiet = ((i / 150) % 4) == 3;
			// long result stall while beats keep coming: block backs up
			if (i == 300)
				hold_out = 1'b1;
			if (i == 650)
				wait_drained();
			case (mode)
				MODE_FILL: begin
					if (tracker.depth() == LIST_CAP && ++overshoot > 5) begin
						mode = MODE_DRAIN;
						overshoot = 0;
					end
				end
				MODE_DRAIN: begin
					if (tracker.depth() == 0 && ++overshoot > 5) begin
						mode = MODE_MIX;
						overshoot = 0;
						mix_left = 80;
					end
				end
				default: begin
					if (--mix_left <= 0)
						mode = MODE_FILL;
				end
			endcase
			send_random_op((mode == MODE_FILL) ? 85 : (mode == MODE_DRAIN) ? 15 : 50);
		end

		wait_drained();
		repeat (150) @(negedge clk);
		if (tracker.mismatches == 0 && tracker.pending() == 0)
			$display("positional_list_insert_remove verification clean");
		else
			$display("positional_list_insert_remove verification failed");
		$finish;
	end

endmodule
